// ----- rtl/pfdd_pkg.sv -----
// ----------------------------------------------------------------------------
// pfdd_pkg: shared types and helpers of the delayed phase-frequency detector
// Widths, register indexes, pump codes, and the saturating time add.
// ----------------------------------------------------------------------------
package pfdd_pkg;

  localparam int TIME_BITS  = 48;
  localparam int EDGE_BITS  = 16;
  localparam int PHASE_BITS = 32;
  localparam int CFG_BITS   = 16;
  // Signed width that holds both a phase and an edge count scaled to Q.16.
  localparam int CMP_BITS   = ((EDGE_BITS + 16 > PHASE_BITS) ? EDGE_BITS + 16 : PHASE_BITS) + 1;

  localparam logic [1:0] CFG_FF_DELAY    = 2'd0;
  localparam logic [1:0] CFG_RESET_DELAY = 2'd1;
  localparam logic [1:0] CFG_MIN_PULSE   = 2'd2;
  localparam logic [1:0] CFG_DEAD_ZONE   = 2'd3;

  typedef enum logic [1:0] {
    PUMP_UP   = 2'd0,
    PUMP_DOWN = 2'd1,
    PUMP_IDLE = 2'd2
  } pump_code_e;

  typedef struct packed {
    logic [CFG_BITS-1:0] ff_delay;
    logic [CFG_BITS-1:0] reset_delay;
    logic [CFG_BITS-1:0] min_pulse;
    logic [CFG_BITS-1:0] dead_zone;
  } cfg_t;

  typedef struct packed {
    logic [TIME_BITS-1:0]         now;
    logic signed [PHASE_BITS-1:0] fb_phase;
    logic signed [PHASE_BITS-1:0] ref_phase;
    logic                         sim_start;
  } sample_t;

  typedef struct packed {
    pump_code_e pump_code;
    logic       changed;
    logic       up_flag;
    logic       down_flag;
  } result_t;

  // Add a delay to a time, clamping at the largest time value.
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] t,
                                                   input logic [CFG_BITS-1:0]  d);
    logic [TIME_BITS:0] sum;
    sum = {1'b0, t} + {{(TIME_BITS + 1 - CFG_BITS){1'b0}}, d};
    return sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  endfunction

  // True once a phase has reached the whole cycle given by the edge count.
  function automatic logic edge_reached(input logic signed [PHASE_BITS-1:0] phase,
                                        input logic [EDGE_BITS-1:0]         cnt);
    logic signed [CMP_BITS-1:0] p;
    logic signed [CMP_BITS-1:0] t;
    p = CMP_BITS'(phase);
    t = $signed({{(CMP_BITS - EDGE_BITS - 16){1'b0}}, cnt, 16'h0000});
    return p >= t;
  endfunction

endpackage

// ----- rtl/phase_frequency_detector_delayed.sv -----
// ----------------------------------------------------------------------------
// phase_frequency_detector_delayed: tri-state PFD with delay and dead zone
// Input sample register, single-step detector core, output result register.
// ----------------------------------------------------------------------------
// Takes one time sample per transaction and returns one result per sample.
// A sample is registered, processed by the detector core, and the result is
// held in an output register, so a new sample is accepted in every clock
// cycle while the output side keeps pace; throughput is one sample per cycle,
// and the result is valid once the sample has passed the sample register and
// the result register, which the output side can stall.
// The combinational detector update (timer compare and saturating add on
// the time word) sets that rate. Configuration writes apply at the next step.
module phase_frequency_detector_delayed (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  input  logic                                     cfg_we_i,
  input  logic [1:0]                               cfg_idx_i,
  input  logic [pfdd_pkg::CFG_BITS-1:0]            cfg_data_i,
  input  logic                                     in_valid_i,
  output logic                                     in_ready_o,
  input  logic [pfdd_pkg::TIME_BITS-1:0]           now_i,
  input  logic signed [pfdd_pkg::PHASE_BITS-1:0]   fb_phase_i,
  input  logic signed [pfdd_pkg::PHASE_BITS-1:0]   ref_phase_i,
  input  logic                                     sim_start_i,
  output logic                                     out_valid_o,
  input  logic                                     out_ready_i,
  output pfdd_pkg::pump_code_e                     pump_code_o,
  output logic                                     changed_o,
  output logic                                     up_flag_o,
  output logic                                     down_flag_o
);
  import pfdd_pkg::*;

  cfg_t    cfg_q;
  sample_t smp_q;
  logic    smp_vld_q;
  result_t res_q, res_d;
  logic    res_vld_q;
  logic    step_en;

  // advance when a sample is held and the result register can take its result
  assign step_en    = smp_vld_q && (!res_vld_q || out_ready_i);
  assign in_ready_o = !smp_vld_q || step_en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ff_delay    <= CFG_BITS'(1);
      cfg_q.reset_delay <= CFG_BITS'(1);
      cfg_q.min_pulse   <= '0;
      cfg_q.dead_zone   <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FF_DELAY:    cfg_q.ff_delay    <= cfg_data_i;
        CFG_RESET_DELAY: cfg_q.reset_delay <= cfg_data_i;
        CFG_MIN_PULSE:   cfg_q.min_pulse   <= cfg_data_i;
        CFG_DEAD_ZONE:   cfg_q.dead_zone   <= cfg_data_i;
        default:         cfg_q.dead_zone   <= cfg_q.dead_zone;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        smp_vld_q <= in_valid_i;
      end
      if (step_en) begin
        res_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      smp_q.now       <= now_i;
      smp_q.fb_phase  <= fb_phase_i;
      smp_q.ref_phase <= ref_phase_i;
      smp_q.sim_start <= sim_start_i;
    end
    if (step_en) begin
      res_q <= res_d;
    end
  end

  pfdd_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_en),
    .sample_i  (smp_q),
    .cfg_i     (cfg_q),
    .result_o  (res_d)
  );

  assign out_valid_o = res_vld_q;
  assign pump_code_o = res_q.pump_code;
  assign changed_o   = res_q.changed;
  assign up_flag_o   = res_q.up_flag;
  assign down_flag_o = res_q.down_flag;

endmodule

// ----- rtl/pfdd_core.sv -----
// ----------------------------------------------------------------------------
// pfdd_core: detector state and single-step update
// Holds edge counters, flip-flops and timers; advances them by one sample.
// ----------------------------------------------------------------------------
module pfdd_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_en_i,
  input  pfdd_pkg::sample_t sample_i,
  input  pfdd_pkg::cfg_t    cfg_i,
  output pfdd_pkg::result_t result_o
);
  import pfdd_pkg::*;

  logic [EDGE_BITS-1:0] fb_cnt_q, fb_cnt_d, ref_cnt_q, ref_cnt_d;
  logic                 up_q, up_d, down_q, down_d;
  logic [2:0]           armed_q, armed_d;
  logic [TIME_BITS-1:0] end0_q, end0_d, end1_q, end1_d, end2_q, end2_d;
  pump_code_e           last_q, last_d;

  // state seen by this step, after an optional start clear
  logic [EDGE_BITS-1:0] fb_cnt_b, ref_cnt_b;
  logic                 up_b, down_b;
  logic [2:0]           armed_b;
  pump_code_e           prev;

  logic signed [PHASE_BITS:0] diff;
  logic [PHASE_BITS:0]        adiff;
  logic                       outside;
  logic                       arm0, arm1, arm2, set0, set1, fire2, cancel;
  logic                       a0, a1, up1, down1;
  logic [TIME_BITS-1:0]       e0, e1, e2, sep;
  pump_code_e                 code;

  always_comb begin
    fb_cnt_b  = sample_i.sim_start ? EDGE_BITS'(1) : fb_cnt_q;
    ref_cnt_b = sample_i.sim_start ? EDGE_BITS'(1) : ref_cnt_q;
    up_b      = sample_i.sim_start ? 1'b0 : up_q;
    down_b    = sample_i.sim_start ? 1'b0 : down_q;
    armed_b   = sample_i.sim_start ? 3'b000 : armed_q;
    prev      = sample_i.sim_start ? PUMP_IDLE : last_q;

    diff    = $signed({sample_i.fb_phase[PHASE_BITS-1], sample_i.fb_phase})
            - $signed({sample_i.ref_phase[PHASE_BITS-1], sample_i.ref_phase});
    adiff   = diff[PHASE_BITS] ? 33'(-diff) : 33'(diff);
    outside = adiff >= {{(PHASE_BITS + 1 - CFG_BITS){1'b0}}, cfg_i.dead_zone};

    // feedback edge drives up, reference edge drives down
    arm0 = edge_reached(sample_i.fb_phase, fb_cnt_b) && !up_b && !armed_b[0];
    arm1 = edge_reached(sample_i.ref_phase, ref_cnt_b) && !down_b && !armed_b[1];
    e0   = arm0 ? sat_add(sample_i.now, cfg_i.ff_delay) : end0_q;
    e1   = arm1 ? sat_add(sample_i.now, cfg_i.ff_delay) : end1_q;
    // a freshly armed end is never below now, so only an older end can expire
    set0 = armed_b[0] && (sample_i.now > end0_q);
    set1 = armed_b[1] && (sample_i.now > end1_q);
    a0   = (armed_b[0] || arm0) && !set0;
    a1   = (armed_b[1] || arm1) && !set1;
    up1  = up_b || set0;
    down1 = down_b || set1;

    sep    = (e1 >= e0) ? e1 - e0 : e0 - e1;
    cancel = a0 && a1 && (sep < {{(TIME_BITS - CFG_BITS){1'b0}}, cfg_i.min_pulse});

    arm2 = up1 && down1 && !armed_b[2];
    e2   = arm2 ? sat_add(sample_i.now, cfg_i.reset_delay) : end2_q;
    // a fresh reset end is reached at once only for zero delay or saturated time
    fire2 = arm2 ? ((cfg_i.reset_delay == '0) || (sample_i.now == {TIME_BITS{1'b1}}))
                 : (armed_b[2] && (sample_i.now >= end2_q));

    fb_cnt_d  = fb_cnt_b;
    ref_cnt_d = ref_cnt_b;
    up_d      = up_b;
    down_d    = down_b;
    armed_d   = armed_b;
    end0_d    = end0_q;
    end1_d    = end1_q;
    end2_d    = end2_q;
    code      = PUMP_IDLE;

    if (outside) begin
      if (edge_reached(sample_i.fb_phase, fb_cnt_b) && !up_b) begin
        fb_cnt_d = fb_cnt_b + EDGE_BITS'(1);
      end
      if (edge_reached(sample_i.ref_phase, ref_cnt_b) && !down_b) begin
        ref_cnt_d = ref_cnt_b + EDGE_BITS'(1);
      end
      end0_d     = e0;
      end1_d     = e1;
      end2_d     = e2;
      armed_d[0] = a0 && !cancel;
      armed_d[1] = a1 && !cancel;
      armed_d[2] = (armed_b[2] || arm2) && !fire2;
      up_d       = up1 && !fire2;
      down_d     = down1 && !fire2;
      priority if (up_d && !down_d) begin
        code = PUMP_UP;
      end else if (!up_d && down_d) begin
        code = PUMP_DOWN;
      end else begin
        code = PUMP_IDLE;
      end
    end
    last_d = code;

    result_o.pump_code = code;
    result_o.changed   = (code != prev);
    result_o.up_flag   = up_d;
    result_o.down_flag = down_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_cnt_q  <= EDGE_BITS'(1);
      ref_cnt_q <= EDGE_BITS'(1);
      up_q      <= 1'b0;
      down_q    <= 1'b0;
      armed_q   <= 3'b000;
      last_q    <= PUMP_IDLE;
    end else if (step_en_i) begin
      fb_cnt_q  <= fb_cnt_d;
      ref_cnt_q <= ref_cnt_d;
      up_q      <= up_d;
      down_q    <= down_d;
      armed_q   <= armed_d;
      last_q    <= last_d;
    end
  end

  // timer ends are only read while their timer is armed
  always_ff @(posedge clk_i) begin
    if (step_en_i) begin
      end0_q <= end0_d;
      end1_q <= end1_d;
      end2_q <= end2_d;
    end
  end

`ifndef NO_ASSERTIONS
  // a delay timer arms only while its flip-flop is low and disarms when it sets
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(armed_q[0] && up_q))
    else $error("up delay timer armed while up is set");
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(armed_q[1] && down_q))
    else $error("down delay timer armed while down is set");
  // the reset timer runs only while both flip-flops are high
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   armed_q[2] |-> (up_q && down_q))
    else $error("reset timer armed without both flags");
  // inside the dead zone a step leaves the flip-flops alone
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (step_en_i && !sample_i.sim_start && !outside)
                   |=> ($stable(up_q) && $stable(down_q) && $stable(armed_q)))
    else $error("dead-zone step changed detector state");
`endif

endmodule
